// ===== hdl/script_source_tokenizer_core_assert.svh =====
// Assertion macros for the tokenizer.
`ifndef SCRIPT_SOURCE_TOKENIZER_CORE_ASSERT_SVH
`define SCRIPT_SOURCE_TOKENIZER_CORE_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define SST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tokenizer check failed");

// Next-cycle implication.
`define SST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tokenizer check failed");

`endif

// ===== hdl/sst_pkg.sv =====
package sst_pkg;
	localparam int POS_WIDTH  = 32;
	localparam int LINE_WIDTH = 24;
	localparam int LEN_WIDTH  = 16;
	localparam int NKW        = 18;
	localparam int MAXRES     = 3;

	typedef logic [5:0] kind_t;
	localparam kind_t K_LPAREN = 6'd0,  K_RPAREN = 6'd1,  K_LBRACE = 6'd2;
	localparam kind_t K_RBRACE = 6'd3,  K_COMMA  = 6'd4,  K_DOT    = 6'd5;
	localparam kind_t K_MINUS  = 6'd6,  K_PLUS   = 6'd7,  K_SEMI   = 6'd8;
	localparam kind_t K_SLASH  = 6'd9,  K_STAR   = 6'd10, K_BANG   = 6'd11;
	localparam kind_t K_BANG_EQ = 6'd12, K_EQ    = 6'd13, K_EQ_EQ  = 6'd14;
	localparam kind_t K_GT     = 6'd15, K_GE     = 6'd16, K_LT     = 6'd17;
	localparam kind_t K_LE     = 6'd18, K_IDENT  = 6'd19, K_STRING = 6'd20;
	localparam kind_t K_NUMBER = 6'd21, K_KW0    = 6'd22, K_EOF    = 6'd40;
	localparam kind_t K_ERR_CHAR = 6'd41, K_ERR_STR = 6'd42;

	typedef enum logic [3:0] {
		M_IDLE, M_IDENT, M_INT, M_DOT, M_FRAC, M_OP, M_STR, M_COMMENT, M_DONE
	} mode_t;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       is_end;
	} in_item_t;

	typedef struct packed {
		kind_t                 token_kind;
		logic [POS_WIDTH-1:0]  token_start;
		logic [LEN_WIDTH-1:0]  token_length;
		logic [LINE_WIDTH-1:0] token_line;
		logic                  last_of_run;
	} out_item_t;

	// Up to three tokens per byte, in order.
	typedef struct packed {
		logic [1:0] count;
		out_item_t  t0;
		out_item_t  t1;
		out_item_t  t2;
	} burst_t;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic logic is_num(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic [3:0] kw_len(input int k);
		logic [3:0] l [NKW] = '{4'd3,4'd5,4'd5,4'd8,4'd4,4'd5,4'd3,4'd3,4'd2,
			4'd3,4'd2,4'd5,4'd6,4'd5,4'd4,4'd4,4'd3,4'd5};
		return l[k];
	endfunction

	// Keyword character at position p (0 past the end).
	function automatic logic [7:0] kw_char(input int k, input int p);
		logic [63:0] t [NKW] = '{"and", "break", "class", "continue", "else",
			"false", "for", "fun", "if", "nil", "or", "print", "return",
			"super", "this", "true", "var", "while"};
		logic [63:0] w;
		int          len;
		w = t[k];
		len = int'(kw_len(k));
		if (p >= len) return 8'd0;
		return w[8*(len-1-p) +: 8];
	endfunction
endpackage

// ===== hdl/sst_scan.sv =====
// Combinational scanner: one byte in, next state and up to three tokens out.
module sst_scan import sst_pkg::*; (
	input  mode_t                 mode,
	input  logic [POS_WIDTH-1:0]  tbegin,
	input  logic [POS_WIDTH-1:0]  pos,
	input  logic [LINE_WIDTH-1:0] line,
	input  logic [LEN_WIDTH-1:0]  run,
	input  logic [NKW-1:0]        alive,
	input  logic [7:0]            held,
	input  in_item_t              item,
	output mode_t                 mode_n,
	output logic [POS_WIDTH-1:0]  tbegin_n,
	output logic [POS_WIDTH-1:0]  pos_n,
	output logic [LINE_WIDTH-1:0] line_n,
	output logic [LEN_WIDTH-1:0]  run_n,
	output logic [NKW-1:0]        alive_n,
	output logic [7:0]            held_n,
	output burst_t                burst
);
	localparam logic [LEN_WIDTH-1:0]  LEN_MAX  = '1;
	localparam logic [LINE_WIDTH-1:0] LINE_MAX = '1;

	logic [7:0] c;
	logic       fin;
	kind_t      idk;
	kind_t      opk1;
	kind_t      opk2;
	logic [LEN_WIDTH-1:0] run_inc;
	logic [LEN_WIDTH-1:0] run_inc2;
	logic [LINE_WIDTH-1:0] line_inc;
	logic [NKW-1:0] fed;

	assign c   = item.char_byte;
	assign fin = item.is_end || c == 8'd0;
	assign run_inc  = (run == LEN_MAX) ? run : run + 1'b1;
	assign run_inc2 = (run_inc == LEN_MAX) ? run_inc : run_inc + 1'b1;
	assign line_inc = (line == LINE_MAX) ? line : line + 1'b1;

	always_comb begin
		idk = K_IDENT;
		for (int k = NKW - 1; k >= 0; k--) begin
			if (alive[k] && run == LEN_WIDTH'(kw_len(k)))
				idk = K_KW0 + kind_t'(k);
		end
	end

	// Keyword filter on the byte at position run.
	always_comb begin
		for (int k = 0; k < NKW; k++) begin
			fed[k] = alive[k] && run < LEN_WIDTH'(kw_len(k)) &&
				kw_char(k, int'(run[3:0])) == c && run < LEN_WIDTH'(8);
		end
	end

	always_comb begin
		unique case (held)
			"!":     begin opk1 = K_BANG; opk2 = K_BANG_EQ; end
			"=":     begin opk1 = K_EQ;   opk2 = K_EQ_EQ;   end
			">":     begin opk1 = K_GT;   opk2 = K_GE;      end
			"<":     begin opk1 = K_LT;   opk2 = K_LE;      end
			default: begin opk1 = K_SLASH; opk2 = K_SLASH;  end
		endcase
	end

	always_comb begin
		out_item_t tk [MAXRES];
		int        n;
		logic      do_idle;
		logic      emit_idle;
		kind_t     ik;
		logic      advance;
		for (int i = 0; i < MAXRES; i++) tk[i] = '0;
		n = 0;
		do_idle = 1'b0;
		emit_idle = 1'b0;
		ik = K_ERR_CHAR;
		advance = 1'b1;
		mode_n = mode; tbegin_n = tbegin; line_n = line; run_n = run;
		alive_n = alive; held_n = held;
		if (mode == M_DONE) begin
			advance = 1'b0;
			tk[0] = '{K_EOF, pos, '0, line, 1'b0}; n = 1;
		end else if (fin) begin
			advance = 1'b0;
			unique case (mode)
				M_IDENT: begin tk[0] = '{idk, tbegin, run, line, 1'b0}; n = 1; end
				M_INT, M_FRAC: begin
					tk[0] = '{K_NUMBER, tbegin, run, line, 1'b0}; n = 1;
				end
				M_DOT: begin
					tk[0] = '{K_NUMBER, tbegin, run, line, 1'b0};
					tk[1] = '{K_DOT, pos - 1'b1, LEN_WIDTH'(1), line, 1'b0}; n = 2;
				end
				M_OP: begin tk[0] = '{opk1, tbegin, LEN_WIDTH'(1), line, 1'b0}; n = 1; end
				M_STR: begin tk[0] = '{K_ERR_STR, tbegin, run, line, 1'b0}; n = 1; end
				default: n = 0;
			endcase
			tk[n] = '{K_EOF, pos, '0, line, 1'b0};
			n = n + 1;
			mode_n = M_DONE;
		end else begin
			unique case (mode)
				M_IDENT: begin
					if (is_letter(c) || is_num(c)) begin
						alive_n = fed; run_n = run_inc;
					end else begin
						tk[0] = '{idk, tbegin, run, line, 1'b0}; n = 1; do_idle = 1'b1;
					end
				end
				M_INT: begin
					if (is_num(c)) run_n = run_inc;
					else if (c == ".") mode_n = M_DOT;
					else begin
						tk[0] = '{K_NUMBER, tbegin, run, line, 1'b0}; n = 1; do_idle = 1'b1;
					end
				end
				M_DOT: begin
					if (is_num(c)) begin run_n = run_inc2; mode_n = M_FRAC; end
					else begin
						tk[0] = '{K_NUMBER, tbegin, run, line, 1'b0};
						tk[1] = '{K_DOT, pos - 1'b1, LEN_WIDTH'(1), line, 1'b0};
						n = 2; do_idle = 1'b1;
					end
				end
				M_FRAC: begin
					if (is_num(c)) run_n = run_inc;
					else begin
						tk[0] = '{K_NUMBER, tbegin, run, line, 1'b0}; n = 1; do_idle = 1'b1;
					end
				end
				M_OP: begin
					if (held == "/") begin
						if (c == "/") mode_n = M_COMMENT;
						else begin
							tk[0] = '{K_SLASH, tbegin, LEN_WIDTH'(1), line, 1'b0};
							n = 1; do_idle = 1'b1;
						end
					end else if (c == "=") begin
						tk[0] = '{opk2, tbegin, LEN_WIDTH'(2), line, 1'b0};
						n = 1; mode_n = M_IDLE;
					end else begin
						tk[0] = '{opk1, tbegin, LEN_WIDTH'(1), line, 1'b0};
						n = 1; do_idle = 1'b1;
					end
				end
				M_STR: begin
					if (c == "\n") line_n = line_inc;
					run_n = run_inc;
					if (c == "\"") begin
						tk[0] = '{K_STRING, tbegin, run_inc, line_n, 1'b0};
						n = 1; mode_n = M_IDLE;
					end
				end
				M_COMMENT: if (c == "\n") do_idle = 1'b1;
				default: do_idle = 1'b1;
			endcase
			if (do_idle) begin
				mode_n = M_IDLE; tbegin_n = pos; run_n = LEN_WIDTH'(1);
				if (c == " " || c == "\t" || c == "\r") emit_idle = 1'b0;
				else if (c == "\n") line_n = line_inc;
				else if (is_letter(c)) begin
					mode_n = M_IDENT;
					for (int k = 0; k < NKW; k++) alive_n[k] = kw_char(k, 0) == c;
				end else if (is_num(c)) mode_n = M_INT;
				else if (c == "!" || c == "=" || c == "<" || c == ">" || c == "/") begin
					held_n = c; mode_n = M_OP;
				end else if (c == "\"") mode_n = M_STR;
				else begin
					emit_idle = 1'b1;
					unique case (c)
						"(": ik = K_LPAREN;
						")": ik = K_RPAREN;
						"{": ik = K_LBRACE;
						"}": ik = K_RBRACE;
						",": ik = K_COMMA;
						".": ik = K_DOT;
						"-": ik = K_MINUS;
						"+": ik = K_PLUS;
						";": ik = K_SEMI;
						"*": ik = K_STAR;
						default: ik = K_ERR_CHAR;
					endcase
				end
				if (emit_idle) begin
					tk[n] = '{ik, pos, LEN_WIDTH'(1), line_n, 1'b0};
					n = n + 1;
				end
			end
		end
		pos_n = advance ? pos + 1'b1 : pos;
		if (n > 0) tk[n-1].last_of_run = 1'b1;
		burst.count = 2'(n);
		burst.t0 = tk[0];
		burst.t1 = tk[1];
		burst.t2 = tk[2];
	end
endmodule

// ===== hdl/sst_outq.sv =====
// Output queue: takes a burst of up to three tokens, drains one per cycle while ready is high.
module sst_outq import sst_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  burst_t    burst,
	output logic      room,
	output logic      valid,
	input  logic      ready,
	output out_item_t data
);
	localparam int DEPTH = 8;
	out_item_t  q_q [DEPTH];
	logic [2:0] rd_q;
	logic [2:0] wr_q;
	logic [3:0] cnt_q;
	logic       pop;

	assign valid = cnt_q != 4'd0;
	assign pop   = valid && ready;
	assign data  = q_q[rd_q];
	// Room for a worst-case burst regardless of pop.
	assign room  = cnt_q <= 4'(DEPTH - MAXRES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0; wr_q <= '0; cnt_q <= '0;
		end else begin
			rd_q  <= rd_q + 3'(pop);
			wr_q  <= wr_q + (push ? 3'(burst.count) : 3'd0);
			cnt_q <= cnt_q + (push ? 4'(burst.count) : 4'd0) - 4'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			if (burst.count > 2'd0) q_q[wr_q]        <= burst.t0;
			if (burst.count > 2'd1) q_q[wr_q + 3'd1] <= burst.t1;
			if (burst.count > 2'd2) q_q[wr_q + 3'd2] <= burst.t2;
		end
	end

	`include "script_source_tokenizer_core_assert.svh"
	`SST_ASSERT_IMP(a_no_overflow, clk, arst_n, push, room)
	`SST_ASSERT_NEXT(a_pop_drops, clk, arst_n, pop && !push, cnt_q == $past(cnt_q) - 4'd1)
	`SST_ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= 4'(DEPTH))
endmodule

// ===== hdl/script_source_tokenizer_core.sv =====
// Streaming tokenizer: one source byte per beat in, tokens out. The scan
// state is registered on each accepted byte, so a byte is taken every cycle
// while the eight-entry output queue has room for the worst case of three
// tokens; ready drops only when the consumer lets the queue fill past five.
// Each byte may yield up to three tokens (e.g. "1." then an operator).
// End of source (is_end or a NUL) flushes the pending token and gives EOF;
// every later beat gives EOF again until reset.
module script_source_tokenizer_core import sst_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);
	mode_t                 mode_q, mode_n;
	logic [POS_WIDTH-1:0]  tbegin_q, tbegin_n, pos_q, pos_n;
	logic [LINE_WIDTH-1:0] line_q, line_n;
	logic [LEN_WIDTH-1:0]  run_q, run_n;
	logic [NKW-1:0]        alive_q, alive_n;
	logic [7:0]            held_q, held_n;
	burst_t                burst;
	logic                  take;

	assign take = in_valid && in_ready;

	sst_scan u_scan (
		.mode(mode_q), .tbegin(tbegin_q), .pos(pos_q), .line(line_q),
		.run(run_q), .alive(alive_q), .held(held_q), .item(in_data),
		.mode_n(mode_n), .tbegin_n(tbegin_n), .pos_n(pos_n), .line_n(line_n),
		.run_n(run_n), .alive_n(alive_n), .held_n(held_n), .burst(burst)
	);

	// Scan state: the tokens of a beat are pushed in the same edge.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE; tbegin_q <= '0; pos_q <= '0;
			line_q <= LINE_WIDTH'(1); run_q <= '0; alive_q <= '1; held_q <= '0;
		end else if (take) begin
			mode_q <= mode_n; tbegin_q <= tbegin_n; pos_q <= pos_n;
			line_q <= line_n; run_q <= run_n; alive_q <= alive_n; held_q <= held_n;
		end
	end

	sst_outq u_outq (
		.clk(clk), .arst_n(arst_n), .push(take), .burst(burst), .room(in_ready),
		.valid(out_valid), .ready(out_ready), .data(out_data)
	);

	`include "script_source_tokenizer_core_assert.svh"
	`SST_ASSERT_NEXT(a_done_sticks, clk, arst_n, mode_q == M_DONE, mode_q == M_DONE)
	`SST_ASSERT_IMP(a_line_nonzero, clk, arst_n, 1'b1, line_q != '0)
	`SST_ASSERT_NEXT(a_done_pos_hold, clk, arst_n, mode_q == M_DONE, $stable(pos_q))
endmodule

// ===== bench/tb.sv =====
module tb;
	import sst_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// Token stream predictor: mirrors the scan state and queues the tokens that
	// each accepted source byte should produce.
	class token_board;
		mode_t             mode;
		logic [31:0]       begin_pos;
		logic [31:0]       pos;
		logic [23:0]       line;
		logic [15:0]       run;
		logic [NKW-1:0]    alive;
		logic [7:0]        held;
		out_item_t         expected_tokens[$];
		out_item_t         step_tokens[$];
		int                errors;

		function new();
			mode = M_IDLE;
			begin_pos = 0;
			pos = 0;
			line = 1;
			run = 0;
			alive = '1;
			held = 0;
			errors = 0;
		endfunction

		function bit letter(logic [7:0] c);
			return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
		endfunction

		function bit digit(logic [7:0] c);
			return c >= "0" && c <= "9";
		endfunction

		function void emit(kind_t k, logic [31:0] s, logic [15:0] l);
			out_item_t t;
			if (step_tokens.size() >= MAXRES) return;
			t.token_kind = k;
			t.token_start = s;
			t.token_length = l;
			t.token_line = line;
			t.last_of_run = 0;
			step_tokens.push_back(t);
		endfunction

		function void bump_run();
			if (run != 16'hFFFF) run++;
		endfunction

		function void bump_line();
			if (line != 24'hFFFFFF) line++;
		endfunction

		function void narrow_keywords(int idx, logic [7:0] c);
			string words[NKW] = '{"and", "break", "class", "continue", "else",
				"false", "for", "fun", "if", "nil", "or", "print", "return",
				"super", "this", "true", "var", "while"};
			for (int k = 0; k < NKW; k++)
				if (idx >= words[k].len() || words[k][idx] != c)
					alive[k] = 0;
		endfunction

		function kind_t word_kind();
			int lens[NKW] = '{3,5,5,8,4,5,3,3,2,3,2,5,6,5,4,4,3,5};
			for (int k = 0; k < NKW; k++)
				if (alive[k] && run == lens[k])
					return kind_t'(K_KW0 + k);
			return K_IDENT;
		endfunction

		function kind_t op_of(bit two);
			case (held)
				"!": return two ? K_BANG_EQ : K_BANG;
				"=": return two ? K_EQ_EQ : K_EQ;
				">": return two ? K_GE : K_GT;
				"<": return two ? K_LE : K_LT;
				default: return K_SLASH;
			endcase
		endfunction

		function void scan_fresh(logic [7:0] c);
			kind_t k;
			mode = M_IDLE;
			begin_pos = pos;
			run = 1;
			if (c == " " || c == "\t" || c == "\r") return;
			if (c == "\n") begin
				bump_line();
				return;
			end
			if (letter(c)) begin
				mode = M_IDENT;
				alive = '1;
				narrow_keywords(0, c);
				return;
			end
			if (digit(c)) begin
				mode = M_INT;
				return;
			end
			case (c)
				"(": k = K_LPAREN;
				")": k = K_RPAREN;
				"{": k = K_LBRACE;
				"}": k = K_RBRACE;
				",": k = K_COMMA;
				".": k = K_DOT;
				"-": k = K_MINUS;
				"+": k = K_PLUS;
				";": k = K_SEMI;
				"*": k = K_STAR;
				"!", "=", "<", ">", "/": begin
					held = c;
					mode = M_OP;
					return;
				end
				"\"": begin
					mode = M_STR;
					return;
				end
				default: k = K_ERR_CHAR;
			endcase
			emit(k, begin_pos, 1);
		endfunction

		function void flush_pending();
			case (mode)
				M_IDENT: emit(word_kind(), begin_pos, run);
				M_INT, M_FRAC: emit(K_NUMBER, begin_pos, run);
				M_DOT: begin
					emit(K_NUMBER, begin_pos, run);
					emit(K_DOT, pos - 1, 1);
				end
				M_OP: emit(op_of(0), begin_pos, 1);
				M_STR: emit(K_ERR_STR, begin_pos, run);
				default: ;
			endcase
		endfunction

		// Accepted input beat: predict its tokens.
		function void note_byte(in_item_t b);
			logic [7:0] c;
			bit stop;
			c = b.char_byte;
			stop = b.is_end || c == 0;
			step_tokens.delete();
			if (mode == M_DONE) begin
				emit(K_EOF, pos, 0);
			end else if (stop) begin
				flush_pending();
				emit(K_EOF, pos, 0);
				mode = M_DONE;
			end else begin
				case (mode)
					M_IDENT:
						if (letter(c) || digit(c)) begin
							narrow_keywords(run, c);
							bump_run();
						end else begin
							emit(word_kind(), begin_pos, run);
							scan_fresh(c);
						end
					M_INT:
						if (digit(c)) bump_run();
						else if (c == ".") mode = M_DOT;
						else begin
							emit(K_NUMBER, begin_pos, run);
							scan_fresh(c);
						end
					M_DOT:
						if (digit(c)) begin
							bump_run();
							bump_run();
							mode = M_FRAC;
						end else begin
							emit(K_NUMBER, begin_pos, run);
							emit(K_DOT, pos - 1, 1);
							scan_fresh(c);
						end
					M_FRAC:
						if (digit(c)) bump_run();
						else begin
							emit(K_NUMBER, begin_pos, run);
							scan_fresh(c);
						end
					M_OP:
						if (held == "/") begin
							if (c == "/") mode = M_COMMENT;
							else begin
								emit(K_SLASH, begin_pos, 1);
								scan_fresh(c);
							end
						end else if (c == "=") begin
							emit(op_of(1), begin_pos, 2);
							mode = M_IDLE;
						end else begin
							emit(op_of(0), begin_pos, 1);
							scan_fresh(c);
						end
					M_STR: begin
						if (c == "\n") bump_line();
						bump_run();
						if (c == "\"") begin
							emit(K_STRING, begin_pos, run);
							mode = M_IDLE;
						end
					end
					M_COMMENT:
						if (c == "\n") scan_fresh(c);
					default: scan_fresh(c);
				endcase
				pos++;
			end
			if (step_tokens.size() > 0)
				step_tokens[step_tokens.size() - 1].last_of_run = 1;
			foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
		endfunction

		// Accepted output beat: compare with the oldest predicted token.
		function void check_token(out_item_t got);
			out_item_t want;
			if (expected_tokens.size() == 0) begin
				$display("%0t: unexpected token %h", $realtime, got);
				errors++;
				return;
			end
			want = expected_tokens.pop_front();
			if (got.token_kind !== want.token_kind) begin
				$display("%0t: kind exp %0d got %0d", $realtime,
					want.token_kind, got.token_kind);
				errors++;
			end
			if (got.token_start !== want.token_start) begin
				$display("%0t: start exp %0d got %0d", $realtime,
					want.token_start, got.token_start);
				errors++;
			end
			if (got.token_length !== want.token_length) begin
				$display("%0t: length exp %0d got %0d", $realtime,
					want.token_length, got.token_length);
				errors++;
			end
			if (got.token_line !== want.token_line) begin
				$display("%0t: line exp %0d got %0d", $realtime,
					want.token_line, got.token_line);
				errors++;
			end
			if (got.last_of_run !== want.last_of_run) begin
				$display("%0t: last exp %0b got %0b", $realtime,
					want.last_of_run, got.last_of_run);
				errors++;
			end
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;

	token_board board = new();
	bit         stim_done = 0;
	bit         idle_mode = 1;  // 1: random gaps and stalls; 0: full rate

	script_source_tokenizer_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("simulation failed");
		$finish;
	end

	// Send one source byte; the gap is drawn per beat. Valid drops only
	// when a gap follows, so back-to-back beats keep it high.
	task automatic send_beat(logic [7:0] c, logic e);
		int gap;
		gap = idle_mode ? $urandom_range(0, 17) : 0;
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			in_valid <= 0;
			in_data <= '{char_byte: 8'($urandom), is_end: 1'($urandom)};
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1;
		in_data <= '{char_byte: c, is_end: e};
		do @(posedge clk); while (!in_ready);
		board.note_byte(in_data);
		@(negedge clk);
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++) send_beat(s[i], 0);
	endtask

	// One source fragment: a word, number, operator, string, comment or a
	// raw byte, with an optional trailing blank.
	task automatic pick_fragment(output string s);
		string words[24] = '{"and", "break", "class", "continue", "else",
			"false", "for", "fun", "if", "nil", "or", "print", "return",
			"super", "this", "true", "var", "while", "rx", "supers", "an",
			"_x9", "returns", "Z"};
		string ops[16] = '{"(", ")", "{", "}", ",", ".", "-", "+", ";", "*",
			"!", "!=", "=", "==", "<=", ">="};
		int k;
		k = $urandom_range(0, 9);
		case (k)
			0, 1: s = words[$urandom_range(0, 23)];
			2: s = $sformatf("%0d", $urandom_range(0, 99999));
			3: s = $sformatf("%0d.%0d", $urandom_range(0, 999), $urandom_range(0, 99));
			4: s = $sformatf("%0d.", $urandom_range(0, 9));
			5, 6: s = ops[$urandom_range(0, 15)];
			7: s = $urandom_range(0, 1) ? "\"ab\ncd\"" : "\"q\"";
			8: s = "// note\n";
			default: begin
				s = " ";
				s[0] = $urandom_range(1, 255);
			end
		endcase
		case ($urandom_range(0, 3))
			0: s = {s, " "};
			1: s = {s, "\n"};
			2: s = {s, "\t"};
			default: ;
		endcase
	endtask

	initial begin
		string frag;
		int    sent;
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		repeat (10) @(negedge clk);
		arst_n = 1;

		// Directed: every operator, keyword edges, numbers, dot cases, errors.
		send_text("(){},.-+;*/ !a!=b=c==d<e<=f>g>=h/x//c\n");
		send_text("fun r return super rx 12.5 3.x 7.\r\t\"s\nt\" ");
		send_beat(8'hFF, 0);
		send_beat(8'h80, 0);
		send_beat("@", 0);

		// Random: mostly well-formed fragments, some raw noise.
		sent = 0;
		while (sent < 160) begin
			if (sent % 60 == 50) idle_mode = !idle_mode;
			pick_fragment(frag);
			send_text(frag);
			sent += frag.len();
		end
		// Unterminated string at end of source, then EOF repeats.
		send_text("\"open");
		send_beat(8'($urandom_range(1, 255)), 1);
		send_beat(0, 0);
		send_beat(8'($urandom), 1);
		in_valid <= 0;
		stim_done = 1;
	end

	// Consumer with random stalls.
	initial begin
		int stall;
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = idle_mode ? $urandom_range(0, 17) : 0;
			if ($urandom_range(0, 3) == 0) stall = 0;
			if (stall > 0) begin
				out_ready <= 0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1;
			do @(posedge clk); while (!out_valid);
			board.check_token(out_data);
		end
	end

	initial begin
		wait (stim_done);
		while (board.expected_tokens.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (board.errors == 0 && board.expected_tokens.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
